[rtl/mscal_pkg.sv]
package mscal_pkg;

    localparam int unsigned TICKS_PER_MINUTE_DEF = 60000;

    localparam int unsigned MINUTES_PER_HOUR = 60;
    localparam int unsigned HOURS_PER_DAY    = 24;
    localparam int unsigned MONTH_WRAP       = 13;
    localparam int unsigned YEAR_LAST        = 99;

    localparam logic [6:0] RST_YEAR  = 7'd24;
    localparam logic [3:0] RST_MONTH = 4'd2;
    localparam logic [4:0] RST_DAY   = 5'd24;

    // command codes; 6 and 7 are no-ops
    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_SET_TIME = 3'd1,
        CMD_RUN_ON   = 3'd2,
        CMD_RUN_OFF  = 3'd3,
        CMD_CAM_ON   = 3'd4,
        CMD_CAM_OFF  = 3'd5
    } cmd_t;

    typedef struct packed {
        logic [6:0]  year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] millis;
    } cal_time_t;

    // first day value that overflows the month
    function automatic logic [5:0] month_limit(input logic [3:0] month,
                                               input logic [6:0] year);
        logic [5:0] lim;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: lim = 6'd32;
            4'd4, 4'd6, 4'd9, 4'd11:                    lim = 6'd31;
            default:                                    lim = (year[1:0] == 2'b00) ? 6'd30 : 6'd29;
        endcase
        return lim;
    endfunction

    // inverse of an odd constant mod 2^16 (elaboration only)
    function automatic logic [15:0] odd_inverse(input logic [15:0] d);
        logic [31:0] x;
        logic [31:0] dw;
        dw = {16'b0, d};
        x  = dw;
        for (int i = 0; i < 4; i++)
        begin
            x = (x * (32'd2 - dw * x)) & 32'h0000_FFFF;
        end
        return x[15:0];
    endfunction

    // value is a multiple of odd d iff value*inv(d) mod 2^16 <= 65535/d
    function automatic logic is_multiple(input logic [15:0] value,
                                         input logic [15:0] inv,
                                         input logic [15:0] limit);
        logic [31:0] prod;
        prod = {16'b0, value} * {16'b0, inv};
        return prod[15:0] <= limit;
    endfunction

endpackage

[rtl/mscal_time_core.sv]
module mscal_time_core #(
    parameter int unsigned TICKS_PER_MINUTE = mscal_pkg::TICKS_PER_MINUTE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  upd,
    input  logic [2:0]            cmd,
    input  mscal_pkg::cal_time_t  set_time,
    output mscal_pkg::cal_time_t  cur_time,
    output logic                  camera_on,
    output logic                  run_flag
);
    import mscal_pkg::*;

    localparam logic [16:0] TpmWide = 17'(TICKS_PER_MINUTE);

    cal_time_t   time_reg, time_next;
    logic        cam_reg, cam_next;
    logic        run_reg, run_next;

    logic [16:0] ms_inc;
    logic [6:0]  min_inc;
    logic [5:0]  hour_inc;
    logic [5:0]  day_inc;
    logic [4:0]  mon_inc;
    logic [4:0]  mon_step;

    always_comb
    begin
        time_next = time_reg;
        cam_next  = cam_reg;
        run_next  = run_reg;
        ms_inc    = {1'b0, time_reg.millis} + 17'd1;
        min_inc   = {1'b0, time_reg.minute} + 7'd1;
        hour_inc  = {1'b0, time_reg.hour} + 6'd1;
        day_inc   = {1'b0, time_reg.day} + 6'd1;
        mon_inc   = {1'b0, time_reg.month} + 5'd1;
        mon_step  = {1'b0, time_reg.month};
        if (upd)
        begin
            unique case (cmd)
                CMD_TICK:
                begin
                    if (ms_inc >= TpmWide)
                    begin
                        time_next.millis = '0;
                        if (min_inc >= 7'(MINUTES_PER_HOUR))
                        begin
                            time_next.minute = '0;
                            if (hour_inc >= 6'(HOURS_PER_DAY))
                            begin
                                time_next.hour = '0;
                                // day carry; month >= 13 wraps even without a day roll
                                if (day_inc >= month_limit(time_reg.month, time_reg.year))
                                begin
                                    time_next.day = 5'd1;
                                    mon_step      = mon_inc;
                                end
                                else
                                begin
                                    time_next.day = day_inc[4:0];
                                end
                                if (mon_step >= 5'(MONTH_WRAP))
                                begin
                                    time_next.month = 4'd1;
                                    time_next.year  = (time_reg.year >= 7'(YEAR_LAST)) ?
                                                      7'd0 : time_reg.year + 7'd1;
                                end
                                else
                                begin
                                    time_next.month = mon_step[3:0];
                                end
                            end
                            else
                            begin
                                time_next.hour = hour_inc[4:0];
                            end
                        end
                        else
                        begin
                            time_next.minute = min_inc[5:0];
                        end
                    end
                    else
                    begin
                        time_next.millis = ms_inc[15:0];
                    end
                end
                CMD_SET_TIME: time_next = set_time;
                CMD_RUN_ON:   run_next  = 1'b1;
                CMD_RUN_OFF:  run_next  = 1'b0;
                CMD_CAM_ON:   cam_next  = 1'b1;
                CMD_CAM_OFF:  cam_next  = 1'b0;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg.year   <= RST_YEAR;
            time_reg.month  <= RST_MONTH;
            time_reg.day    <= RST_DAY;
            time_reg.hour   <= '0;
            time_reg.minute <= '0;
            time_reg.millis <= '0;
            cam_reg         <= 1'b0;
            run_reg         <= 1'b0;
        end
        else
        begin
            time_reg <= time_next;
            cam_reg  <= cam_next;
            run_reg  <= run_next;
        end
    end

    assign cur_time  = time_reg;
    assign camera_on = cam_reg;
    assign run_flag  = run_reg;

`ifndef ASSERT_OFF
    a_run_set: assert property (@(posedge clk) disable iff (!rst_n)
        (upd && cmd == CMD_RUN_ON) |=> run_reg)
        else $error("run flag not set after run-on");
    a_ms_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (upd && cmd == CMD_TICK && ms_inc >= TpmWide) |=> (time_reg.millis == '0))
        else $error("millis did not wrap at end of minute");
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !upd |=> $stable(time_reg))
        else $error("time changed without an accepted word");
`endif
endmodule

[rtl/mscal_pulse_stage.sv]
module mscal_pulse_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic                  tick,
    input  logic                  camera_on,
    input  logic                  run_flag,
    input  mscal_pkg::cal_time_t  cur_time,
    input  logic                  out_stall,
    output logic                  free,
    output logic                  out_valid,
    output logic                  pps_pulse,
    output logic                  time_msg_due,
    output logic                  camera_trigger,
    output logic                  imu_forward_due,
    output logic                  run_on,
    output mscal_pkg::cal_time_t  out_time
);
    import mscal_pkg::*;

    // 1000 = 8*125, 100 = 4*25, 20 = 4*5: low zero bits plus an odd-divisor test
    localparam logic [15:0] Inv125 = odd_inverse(16'd125);
    localparam logic [15:0] Inv25  = odd_inverse(16'd25);
    localparam logic [15:0] Inv5   = odd_inverse(16'd5);
    localparam logic [15:0] Lim125 = 16'(65535 / 125);
    localparam logic [15:0] Lim25  = 16'(65535 / 25);
    localparam logic [15:0] Lim5   = 16'(65535 / 5);

    logic      valid_reg, valid_next;
    logic      pps_reg, tmsg_reg, cam_reg, imu_reg, run_reg;
    logic      pps_next, tmsg_next, imu_next;
    cal_time_t time_reg;

    always_comb
    begin
        pps_next  = tick && (cur_time.millis[2:0] == 3'b000) &&
                    is_multiple({3'b0, cur_time.millis[15:3]}, Inv125, Lim125);
        tmsg_next = tick && (cur_time.millis[1:0] == 2'b00) &&
                    is_multiple({2'b0, cur_time.millis[15:2]}, Inv25, Lim25);
        imu_next  = tick && (cur_time.millis[1:0] == 2'b00) &&
                    is_multiple({2'b0, cur_time.millis[15:2]}, Inv5, Lim5);
    end

    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pps_reg  <= pps_next;
            tmsg_reg <= tmsg_next;
            cam_reg  <= tmsg_next && camera_on;
            imu_reg  <= imu_next;
            run_reg  <= run_flag;
            time_reg <= cur_time;
        end
    end

    assign out_valid       = valid_reg;
    assign pps_pulse       = pps_reg;
    assign time_msg_due    = tmsg_reg;
    assign camera_trigger  = cam_reg;
    assign imu_forward_due = imu_reg;
    assign run_on          = run_reg;
    assign out_time        = time_reg;

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("output register loaded while a word is held");
    a_pps_nest: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && pps_reg) |-> (tmsg_reg && imu_reg))
        else $error("pps pulse without 10 Hz and 50 Hz pulses");
    a_cam_nest: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && cam_reg) |-> tmsg_reg)
        else $error("camera trigger off the 100 ms grid");
`endif
endmodule

[rtl/ms_calendar_clock_trigger_gen.sv]
// Millisecond calendar clock and trigger generator. Each input word carries a
// command: tick (advance one millisecond with carry through minute, hour, day,
// month and a two-digit year that wraps 99 -> 0; February has 29 days when
// year mod 4 is zero, else 28), set time (all fields loaded unchecked), run
// on/off, camera on/off. Codes 6 and 7 are no-ops. Every input word yields
// exactly one output word holding the date/time and run flag after that word,
// plus pulses on ticks only: pps_pulse when the new millis is a multiple of
// 1000, time_msg_due on multiples of 100, camera_trigger on those while the
// camera is on, imu_forward_due on multiples of 20. Throughput is one word
// per clock while the output is not stalled; an accepted word passes the
// state register, then the output register that holds the pulse decode,
// before out_valid rises and the word can be taken by the receiver. Reset date
// is day 24, month 2, year 24 at 00:00:00.000. Both sides use valid/stall;
// in_stall rises only when both stages hold words and the output is stalled.
module ms_calendar_clock_trigger_gen #(
    parameter int unsigned TICKS_PER_MINUTE = mscal_pkg::TICKS_PER_MINUTE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [6:0]  set_year,
    input  logic [3:0]  set_month,
    input  logic [4:0]  set_day,
    input  logic [4:0]  set_hour,
    input  logic [5:0]  set_minute,
    input  logic [15:0] set_millis,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        pps_pulse,
    output logic        time_msg_due,
    output logic        camera_trigger,
    output logic        imu_forward_due,
    output logic        run_on,
    output logic [6:0]  cur_year,
    output logic [3:0]  cur_month,
    output logic [4:0]  cur_day,
    output logic [4:0]  cur_hour,
    output logic [5:0]  cur_minute,
    output logic [15:0] cur_millis
);
    import mscal_pkg::*;

    // stage A: the calendar state itself is the payload; only valid and
    // the tick flag are kept alongside it
    logic      a_valid_reg, a_valid_next;
    logic      tick_reg;
    logic      b_free;
    logic      a_adv;
    logic      accept;
    cal_time_t set_time;
    cal_time_t state_time;
    cal_time_t out_time;
    logic      camera_on;
    logic      run_flag;

    assign a_adv    = a_valid_reg && b_free;
    assign in_stall = a_valid_reg && !b_free;
    assign accept   = in_valid && !in_stall;

    assign set_time = '{year: set_year, month: set_month, day: set_day,
                        hour: set_hour, minute: set_minute, millis: set_millis};

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_adv)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tick_reg <= (cmd == CMD_TICK);
        end
    end

    mscal_time_core #(
        .TICKS_PER_MINUTE (TICKS_PER_MINUTE)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (accept),
        .cmd       (cmd),
        .set_time  (set_time),
        .cur_time  (state_time),
        .camera_on (camera_on),
        .run_flag  (run_flag)
    );

    mscal_pulse_stage u_pulse (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (a_adv),
        .tick            (tick_reg),
        .camera_on       (camera_on),
        .run_flag        (run_flag),
        .cur_time        (state_time),
        .out_stall       (out_stall),
        .free            (b_free),
        .out_valid       (out_valid),
        .pps_pulse       (pps_pulse),
        .time_msg_due    (time_msg_due),
        .camera_trigger  (camera_trigger),
        .imu_forward_due (imu_forward_due),
        .run_on          (run_on),
        .out_time        (out_time)
    );

    assign cur_year   = out_time.year;
    assign cur_month  = out_time.month;
    assign cur_day    = out_time.day;
    assign cur_hour   = out_time.hour;
    assign cur_minute = out_time.minute;
    assign cur_millis = out_time.millis;

`ifndef ASSERT_OFF
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (a_valid_reg && out_valid && out_stall))
        else $error("input stalled with room in the pipe");
    a_tick_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == CMD_TICK) |=> (a_valid_reg && tick_reg))
        else $error("tick word not staged");
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && b_free && !accept) |=> !a_valid_reg)
        else $error("stage A kept a word it handed on");
`endif
endmodule

[dv/tb_ms_calendar_clock_trigger_gen.sv]
`timescale 1ns / 100ps

module tb_ms_calendar_clock_trigger_gen;

    import mscal_pkg::*;

    localparam int unsigned TICK_MS = TICKS_PER_MINUTE_DEF;

    // the two command codes the block ignores
    localparam logic [2:0] CMD_NOP_A = 3'd6;
    localparam logic [2:0] CMD_NOP_B = 3'd7;

    localparam int unsigned WORD_GOAL   = 1800;
    localparam int unsigned QUIET_FIRST = 700;   // no idling on either side
    localparam int unsigned QUIET_LAST  = 1000;  // for words in this window

    // one output word: pulses, run flag, then the date and time after the word
    typedef struct packed {
        logic      pps;
        logic      tmsg;
        logic      cam;
        logic      imu;
        logic      run;
        cal_time_t t;
    } readout_t;

    // ------------------------------------------------------------------
    // Calendar predictor plus the queue of readouts still owed by the DUT.
    // ------------------------------------------------------------------
    class calendar_board;
        cal_time_t   now = '{year: RST_YEAR, month: RST_MONTH, day: RST_DAY,
                            hour: 5'd0, minute: 6'd0, millis: 16'd0};
        bit          cam_en   = 1'b0;
        bit          run_flag = 1'b0;
        readout_t    pending_readouts[$];
        int unsigned fails = 0, checked = 0, ticks = 0;
        int unsigned pps_seen = 0, trig_seen = 0, day_rolls = 0;

        // advance one millisecond; every carry compares the widened value
        function void advance_ms();
            int unsigned ms, mi, hr, dy, mo, lim;
            ms = now.millis + 1;
            if (ms >= TICK_MS)
            begin
                ms = 0;
                mi = now.minute + 1;
                if (mi >= MINUTES_PER_HOUR)
                begin
                    mi = 0;
                    hr = now.hour + 1;
                    if (hr >= HOURS_PER_DAY)
                    begin
                        hr = 0;
                        day_rolls++;
                        case (now.month)
                            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: lim = 32;
                            4'd4, 4'd6, 4'd9, 4'd11:                    lim = 31;
                            default: lim = (now.year % 4 == 0) ? 30 : 29;
                        endcase
                        dy = now.day + 1;
                        mo = now.month;
                        if (dy >= lim)
                        begin
                            dy = 1;
                            mo = now.month + 1;
                        end
                        // checked on every day advance, carry or not
                        if (mo >= MONTH_WRAP)
                        begin
                            mo = 1;
                            now.year = (now.year >= YEAR_LAST) ? 7'd0 : 7'(now.year + 1);
                        end
                        now.day   = 5'(dy);
                        now.month = 4'(mo);
                    end
                    now.hour = 5'(hr);
                end
                now.minute = 6'(mi);
            end
            now.millis = 16'(ms);
        endfunction

        // accepted input word -> expected readout
        function void note_word(logic [2:0] c, cal_time_t setv);
            readout_t want;
            want = '0;
            case (c)
                CMD_TICK:
                begin
                    advance_ms();
                    ticks++;
                    want.pps  = (now.millis % 1000 == 0);
                    want.tmsg = (now.millis % 100 == 0);
                    want.cam  = want.tmsg & cam_en;
                    want.imu  = (now.millis % 20 == 0);
                    pps_seen  += want.pps;
                    trig_seen += want.cam;
                end
                CMD_SET_TIME: now      = setv;
                CMD_RUN_ON:   run_flag = 1'b1;
                CMD_RUN_OFF:  run_flag = 1'b0;
                CMD_CAM_ON:   cam_en   = 1'b1;
                CMD_CAM_OFF:  cam_en   = 1'b0;
                default: ;
            endcase
            want.run = run_flag;
            want.t   = now;
            pending_readouts.push_back(want);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                fails++;
            end
        endfunction

        function void check_word(readout_t got);
            readout_t want;
            if (pending_readouts.size() == 0)
            begin
                $error("output word with nothing expected: %h", got);
                fails++;
                return;
            end
            want = pending_readouts.pop_front();
            checked++;
            check_field("pps_pulse",       want.pps,      got.pps);
            check_field("time_msg_due",    want.tmsg,     got.tmsg);
            check_field("camera_trigger",  want.cam,      got.cam);
            check_field("imu_forward_due", want.imu,      got.imu);
            check_field("run_on",          want.run,      got.run);
            check_field("cur_year",        want.t.year,   got.t.year);
            check_field("cur_month",       want.t.month,  got.t.month);
            check_field("cur_day",         want.t.day,    got.t.day);
            check_field("cur_hour",        want.t.hour,   got.t.hour);
            check_field("cur_minute",      want.t.minute, got.t.minute);
            check_field("cur_millis",      want.t.millis, got.t.millis);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT and stimulus signals; all inputs start at known values.
    // ------------------------------------------------------------------
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [2:0]  cmd        = CMD_TICK;
    logic [6:0]  set_year   = '0;
    logic [3:0]  set_month  = '0;
    logic [4:0]  set_day    = '0;
    logic [4:0]  set_hour   = '0;
    logic [5:0]  set_minute = '0;
    logic [15:0] set_millis = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic        pps_pulse, time_msg_due, camera_trigger, imu_forward_due, run_on;
    logic [6:0]  cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [15:0] cur_millis;

    calendar_board board = new();
    int unsigned   words_sent = 0;   // codes 6/7 not counted
    bit            quiet = 1'b0;

    ms_calendar_clock_trigger_gen #(
        .TICKS_PER_MINUTE(TICK_MS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .set_year(set_year),
        .set_month(set_month),
        .set_day(set_day),
        .set_hour(set_hour),
        .set_minute(set_minute),
        .set_millis(set_millis),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .pps_pulse(pps_pulse),
        .time_msg_due(time_msg_due),
        .camera_trigger(camera_trigger),
        .imu_forward_due(imu_forward_due),
        .run_on(run_on),
        .cur_year(cur_year),
        .cur_month(cur_month),
        .cur_day(cur_day),
        .cur_hour(cur_hour),
        .cur_minute(cur_minute),
        .cur_millis(cur_millis)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ~21% idle per cycle on each side, none during the quiet window
    function automatic bit idle_now();
        return !quiet && ($urandom_range(0, 99) < 21);
    endfunction

    function automatic cal_time_t at_time(int unsigned y, int unsigned mo, int unsigned d,
                                          int unsigned h, int unsigned mi, int unsigned ms);
        return '{year: 7'(y), month: 4'(mo), day: 5'(d),
                 hour: 5'(h), minute: 6'(mi), millis: 16'(ms)};
    endfunction

    function automatic cal_time_t any_time();
        return cal_time_t'({$urandom, $urandom});
    endfunction

    // Drive one word and hold it until accepted. Entered right after a
    // rising edge; in_valid gets exactly one assignment per time step.
    task automatic send_word(input logic [2:0] c, input cal_time_t t);
        quiet = (words_sent >= QUIET_FIRST) && (words_sent < QUIET_LAST);
        while (idle_now())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        set_year   <= t.year;
        set_month  <= t.month;
        set_day    <= t.day;
        set_hour   <= t.hour;
        set_minute <= t.minute;
        set_millis <= t.millis;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // accepted at this edge
        board.note_word(c, t);
        if (c != CMD_NOP_A && c != CMD_NOP_B)
            words_sent++;
    endtask

    // Settable time near a boundary: month ends, 23:59 and millis just
    // short of a minute, a second or a 100 ms mark.
    task automatic send_boundary_run();
        cal_time_t   t;
        int unsigned n;
        t.year   = 7'($urandom_range(0, 99));
        t.month  = 4'($urandom_range(1, 12));
        t.day    = $urandom_range(0, 1) ? 5'($urandom_range(28, 31))
                                        : 5'($urandom_range(1, 31));
        t.hour   = $urandom_range(0, 1) ? 5'd23 : 5'($urandom_range(0, 23));
        t.minute = $urandom_range(0, 1) ? 6'd59 : 6'($urandom_range(0, 59));
        case ($urandom_range(0, 3))
            0: t.millis = 16'(59999 - $urandom_range(0, 12));
            1: t.millis = 16'($urandom_range(1, 59) * 1000 - $urandom_range(1, 12));
            2: t.millis = 16'($urandom_range(0, 59999));
            default: t.millis = 16'($urandom_range(1, 599) * 100 - $urandom_range(1, 5));
        endcase
        send_word(CMD_SET_TIME, t);
        n = $urandom_range(1, 24);
        repeat (n)
        begin
            // now and then flip the run flag or the camera mid-run
            if ($urandom_range(0, 9) == 0)
                send_word(3'($urandom_range(CMD_RUN_ON, CMD_CAM_OFF)), any_time());
            else
                send_word(CMD_TICK, any_time());
        end
    endtask

    // receiver: check accepted words, stall at random
    always @(posedge clk)
    begin
        readout_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {pps_pulse, time_msg_due, camera_trigger, imu_forward_due, run_on,
                   cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_millis};
            board.check_word(got);
        end
        out_stall <= rst_n && idle_now();
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        send_word(CMD_TICK, '0);                 // first tick from reset date
        send_word(CMD_NOP_A, any_time());        // unused codes: no effect
        send_word(CMD_NOP_B, any_time());
        send_word(CMD_RUN_ON, '0);
        send_word(CMD_CAM_ON, '0);
        // year wrap 99 -> 0 at New Year
        send_word(CMD_SET_TIME, at_time(99, 12, 31, 23, 59, 59999));
        send_word(CMD_TICK, '0);
        // leap February, then plain February, then a 30-day month
        send_word(CMD_SET_TIME, at_time(24, 2, 29, 23, 59, 59999));
        send_word(CMD_TICK, '0);
        send_word(CMD_SET_TIME, at_time(23, 2, 28, 23, 59, 59999));
        send_word(CMD_TICK, '0);
        send_word(CMD_SET_TIME, at_time(23, 4, 30, 23, 59, 59999));
        send_word(CMD_TICK, '0);
        // whole second with camera on: all four pulses
        send_word(CMD_SET_TIME, at_time(5, 6, 15, 10, 30, 999));
        send_word(CMD_TICK, '0);
        // camera off: 100 ms mark without trigger, then a 20 ms-only mark
        send_word(CMD_CAM_OFF, '0);
        send_word(CMD_SET_TIME, at_time(5, 6, 15, 10, 30, 1099));
        send_word(CMD_TICK, '0);
        send_word(CMD_SET_TIME, at_time(5, 6, 15, 10, 30, 1119));
        send_word(CMD_TICK, '0);
        send_word(CMD_RUN_OFF, '0);
        // every field at all ones (day 31, the rest out of range), then all zeros
        send_word(CMD_SET_TIME, '1);
        send_word(CMD_TICK, '0);
        send_word(CMD_SET_TIME, '0);
        send_word(CMD_TICK, '0);

        // --- random: mostly boundary runs, some raw noise ---
        while (words_sent < WORD_GOAL)
        begin
            if ($urandom_range(0, 99) < 70)
                send_boundary_run();
            else
                repeat ($urandom_range(1, 4))
                    send_word(3'($urandom_range(0, 7)), any_time());
        end
        in_valid <= 1'b0;

        // drain, then give the pipeline time to show any extra word
        while (board.pending_readouts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("checked %0d words: %0d ticks, %0d PPS pulses, %0d camera triggers,",
                 board.checked, board.ticks, board.pps_seen, board.trig_seen);
        $display("%0d day rollovers, set-time with out-of-range fields and unused codes",
                 board.day_rolls);
        if (board.fails == 0)
            $display("** ms_calendar_clock_trigger_gen: PASSED **");
        else
            $display("** ms_calendar_clock_trigger_gen: FAILED **");
        $finish;
    end

    // watchdog
    initial
    begin
        #3_000_000;
        $display("timeout: %0d words still expected", board.pending_readouts.size());
        $display("** ms_calendar_clock_trigger_gen: FAILED **");
        $finish;
    end

endmodule

[ms_calendar_clock_trigger_gen.f]
rtl/mscal_pkg.sv
rtl/mscal_time_core.sv
rtl/mscal_pulse_stage.sv
rtl/ms_calendar_clock_trigger_gen.sv
dv/tb_ms_calendar_clock_trigger_gen.sv
